### hw/rtl/mfvn_pkg.sv
// ----------------------------------------------------------------------------
// mfvn_pkg
// Shared types and constants for the mesh face and vertex normal block.
// ----------------------------------------------------------------------------
package mfvn_pkg;

  // Fixed field widths.
  localparam int IDX_W    = 12;
  localparam int CNT_W    = 13;
  localparam int IN_W     = 16;
  localparam int OUT_W    = 16;
  localparam int ACC_W    = 44;
  localparam int ONE_Q14  = 16384;

  // Defaults for the top-level parameters.
  localparam int DEF_VERTEX_DEPTH = 4096;
  localparam int DEF_COORD_WIDTH  = 16;

  // Command modes.
  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_FACE = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;

  // Result kinds.
  localparam logic KIND_FACE   = 1'b0;
  localparam logic KIND_VERTEX = 1'b1;

  // Error codes.
  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_INDEX = 2'd1;
  localparam logic [1:0] ERR_ZERO  = 2'd2;

  // Status of the normalizer toward the sequencer.
  typedef struct packed {
    logic done;
    logic zero;
  } norm_res_t;

endpackage

### hw/rtl/mfvn_norm.sv
// ----------------------------------------------------------------------------
// mfvn_norm
// Iterative vector normalizer: scales, squares, takes an integer square root
// and divides each component, one step per cycle.
// ----------------------------------------------------------------------------
module mfvn_norm
  import mfvn_pkg::*;
#(
  parameter int NVW = 52
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic signed [NVW-1:0] vx_i,
  input  logic signed [NVW-1:0] vy_i,
  input  logic signed [NVW-1:0] vz_i,
  output norm_res_t             res_o,
  output logic [OUT_W-1:0]      nx_o,
  output logic [OUT_W-1:0]      ny_o,
  output logic [OUT_W-1:0]      nz_o
);

  typedef enum logic [5:0] {
    N_IDLE  = 6'b000001,
    N_SHIFT = 6'b000010,
    N_SQ    = 6'b000100,
    N_SQADD = 6'b001000,
    N_ROOT  = 6'b010000,
    N_DIV   = 6'b100000
  } nstate_e;

  localparam logic [NVW-1:0] HI_LIM = NVW'(64'd1 << 30);
  localparam logic [NVW-1:0] LO_LIM = NVW'(64'd1 << 29);

  nstate_e           state_q, state_d;
  logic [NVW-1:0]    m_q [3];
  logic [NVW-1:0]    m_d [3];
  logic [2:0]        neg_q, neg_d;
  logic [1:0]        k_q, k_d;
  logic [59:0]       prod_q, prod_d;
  logic [61:0]       s_q, s_d, r_q, r_d, bit_q, bit_d;
  logic [47:0]       rem_q, rem_d;
  logic [15:0]       quo_q, quo_d;
  logic [3:0]        i_q, i_d;
  logic [OUT_W-1:0]  out_q [3];
  logic [OUT_W-1:0]  out_d [3];
  norm_res_t         res_q, res_d;

  logic [NVW-1:0]    top;
  logic [NVW-1:0]    m_cur;
  logic [62:0]       trial;
  logic [31:0]       len;
  logic [47:0]       dsh;
  logic              ge;
  logic [15:0]       qn;
  logic [15:0]       qc;
  logic [1:0]        k_nx;

  // Largest magnitude and the component under work.
  always_comb begin
    top = (m_q[0] > m_q[1]) ? m_q[0] : m_q[1];
    if (m_q[2] > top) top = m_q[2];
    case (k_q)
      2'd0:    m_cur = m_q[0];
      2'd1:    m_cur = m_q[1];
      default: m_cur = m_q[2];
    endcase
    trial = {1'b0, r_q} + {1'b0, bit_q};
    len   = r_q[31:0];
    dsh   = 48'(len) << i_q;
    ge    = rem_q >= dsh;
    qn    = ge ? (quo_q | (16'd1 << i_q)) : quo_q;
    qc    = (qn > 16'(ONE_Q14)) ? 16'(ONE_Q14) : qn;
    k_nx  = k_q + 2'd1;
  end

  // Sequencer of the normalizer.
  always_comb begin
    state_d = state_q;
    m_d     = m_q;
    neg_d   = neg_q;
    k_d     = k_q;
    prod_d  = prod_q;
    s_d     = s_q;
    r_d     = r_q;
    bit_d   = bit_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    i_d     = i_q;
    out_d   = out_q;
    res_d   = '{done: 1'b0, zero: res_q.zero};
    case (state_q)
      N_IDLE: begin
        if (start_i) begin
          m_d[0]  = vx_i[NVW-1] ? NVW'(-vx_i) : NVW'(vx_i);
          m_d[1]  = vy_i[NVW-1] ? NVW'(-vy_i) : NVW'(vy_i);
          m_d[2]  = vz_i[NVW-1] ? NVW'(-vz_i) : NVW'(vz_i);
          neg_d   = {vz_i[NVW-1], vy_i[NVW-1], vx_i[NVW-1]};
          state_d = N_SHIFT;
        end
      end
      N_SHIFT: begin
        // One bit of scaling per cycle until the top lies in [2^29, 2^30).
        if (top == '0) begin
          out_d   = '{default: '0};
          res_d   = '{done: 1'b1, zero: 1'b1};
          state_d = N_IDLE;
        end else if (top >= HI_LIM) begin
          for (int c = 0; c < 3; c++) m_d[c] = m_q[c] >> 1;
        end else if (top < LO_LIM) begin
          for (int c = 0; c < 3; c++) m_d[c] = m_q[c] << 1;
        end else begin
          k_d     = 2'd0;
          s_d     = '0;
          state_d = N_SQ;
        end
      end
      N_SQ: begin
        prod_d  = 60'(m_cur[29:0]) * 60'(m_cur[29:0]);
        state_d = N_SQADD;
      end
      N_SQADD: begin
        s_d = s_q + 62'(prod_q);
        if (k_q == 2'd2) begin
          r_d     = '0;
          bit_d   = 62'd1 << 60;
          state_d = N_ROOT;
        end else begin
          k_d     = k_nx;
          state_d = N_SQ;
        end
      end
      N_ROOT: begin
        // Restoring square root, one result bit per cycle.
        if (bit_q != '0) begin
          if ({1'b0, s_q} >= trial) begin
            s_d = s_q - trial[61:0];
            r_d = (r_q >> 1) + bit_q;
          end else begin
            r_d = r_q >> 1;
          end
          bit_d = bit_q >> 2;
        end else begin
          k_d     = 2'd0;
          rem_d   = (48'(m_q[0][29:0]) << 14) + 48'(len[31:1]);
          quo_d   = '0;
          i_d     = 4'd15;
          state_d = N_DIV;
        end
      end
      N_DIV: begin
        // Restoring division, one quotient bit per cycle.
        rem_d = ge ? rem_q - dsh : rem_q;
        quo_d = qn;
        i_d   = i_q - 4'd1;
        if (i_q == 4'd0) begin
          case (k_q)
            2'd0:    out_d[0] = neg_q[0] ? -qc : qc;
            2'd1:    out_d[1] = neg_q[1] ? -qc : qc;
            default: out_d[2] = neg_q[2] ? -qc : qc;
          endcase
          if (k_q == 2'd2) begin
            res_d   = '{done: 1'b1, zero: 1'b0};
            state_d = N_IDLE;
          end else begin
            k_d   = k_nx;
            quo_d = '0;
            i_d   = 4'd15;
            case (k_nx)
              2'd1:    rem_d = (48'(m_q[1][29:0]) << 14) + 48'(len[31:1]);
              default: rem_d = (48'(m_q[2][29:0]) << 14) + 48'(len[31:1]);
            endcase
          end
        end
      end
      default: state_d = N_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= N_IDLE;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    m_q    <= m_d;
    neg_q  <= neg_d;
    k_q    <= k_d;
    prod_q <= prod_d;
    s_q    <= s_d;
    r_q    <= r_d;
    bit_q  <= bit_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    i_q    <= i_d;
    out_q  <= out_d;
  end

  assign res_o = res_q;
  assign nx_o  = out_q[0];
  assign ny_o  = out_q[1];
  assign nz_o  = out_q[2];

endmodule

### hw/rtl/mesh_face_vertex_normals.sv
// ----------------------------------------------------------------------------
// mesh_face_vertex_normals
// Stores mesh vertices, accumulates area-weighted normals per vertex and
// returns normalized face and vertex normals.
// ----------------------------------------------------------------------------
// A load writes the vertex; an index error goes straight to the result. A face
// fetches, forms the cross product and accumulates it, then normalizes; a read
// fetches the accumulator, then normalizes. The normalizer scales one bit at a
// time, then squares, takes the root and does the three divides.
// One transaction at a time; busy_o is high meanwhile. Reset clears the control
// state and vertex_count only. Results strobe valid_o; the receiver cannot stall.
module mesh_face_vertex_normals
  import mfvn_pkg::*;
#(
  parameter int VERTEX_DEPTH = DEF_VERTEX_DEPTH,
  parameter int COORD_WIDTH  = DEF_COORD_WIDTH
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CNT_W-1:0]        cfg_data_i,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic [1:0]              mode_i,
  input  logic [IDX_W-1:0]        first_index_i,
  input  logic [IDX_W-1:0]        second_index_i,
  input  logic [IDX_W-1:0]        third_index_i,
  input  logic signed [IN_W-1:0]  coord_x_i,
  input  logic signed [IN_W-1:0]  coord_y_i,
  input  logic signed [IN_W-1:0]  coord_z_i,
  input  logic                    last_face_i,
  output logic                    valid_o,
  output logic signed [OUT_W-1:0] normal_x_o,
  output logic signed [OUT_W-1:0] normal_y_o,
  output logic signed [OUT_W-1:0] normal_z_o,
  output logic                    normal_kind_o,
  output logic [1:0]              error_code_o
);

  localparam int CW      = COORD_WIDTH;
  localparam int AW      = $clog2(VERTEX_DEPTH);
  localparam int CROSS_W = 2 * CW + 3;
  localparam int NVW     = (CROSS_W > ACC_W) ? CROSS_W : ACC_W;
  localparam logic signed [NVW:0] ACC_HI = (NVW+1)'((64'sd1 <<< (ACC_W - 1)) - 64'sd1);
  localparam logic signed [NVW:0] ACC_LO = -ACC_HI - (NVW+1)'(1);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_DECODE = 11'b00000000010,
    S_VRD    = 11'b00000000100,
    S_VLT    = 11'b00000001000,
    S_MUL    = 11'b00000010000,
    S_ADD    = 11'b00000100000,
    S_ARD    = 11'b00001000000,
    S_AWR    = 11'b00010000000,
    S_NORM   = 11'b00100000000,
    S_NWAIT  = 11'b01000000000,
    S_DONE   = 11'b10000000000
  } state_e;

  state_e                 state_q, state_d;
  logic [1:0]             mode_q;
  logic [IDX_W-1:0]       idx_q [3];
  logic [CW-1:0]          cx_q, cy_q, cz_q;
  logic [CNT_W-1:0]       cnt_q;
  logic [2:0]             k_q, k_d;
  logic [3*CW-1:0]        vreg_q [3];
  logic signed [2*CW+1:0] prod_q;
  logic signed [NVW-1:0]  cross_q [3];
  logic signed [NVW-1:0]  cross_d [3];
  logic [OUT_W-1:0]       res_n_q [3];
  logic [OUT_W-1:0]       res_n_d [3];
  logic [1:0]             res_err_q, res_err_d;
  logic                   res_kind_q, res_kind_d;
  logic                   valid_q, valid_d;
  logic                   vreg_we;

  // Memory ports.
  logic                   v_we, a_we;
  logic [AW-1:0]          v_waddr, a_waddr, rd_addr;
  logic [3*CW-1:0]        vmem [VERTEX_DEPTH];
  logic [3*CW-1:0]        v_rdata_q;
  logic [3*ACC_W-1:0]     amem [VERTEX_DEPTH];
  logic [3*ACC_W-1:0]     a_wdata, a_rdata_q;

  // Normalizer link.
  logic                   norm_start;
  logic signed [NVW-1:0]  norm_in [3];
  norm_res_t              norm_res;
  logic [OUT_W-1:0]       norm_x, norm_y, norm_z;

  logic [IDX_W-1:0]       cur_idx;
  logic [2:0]             idx_ok;
  logic signed [CW:0]     e1 [3];
  logic signed [CW:0]     e2 [3];
  logic signed [CW:0]     op_a, op_b;
  logic signed [ACC_W-1:0] acc_lane [3];
  logic signed [NVW:0]    sum_lane [3];

  // Index checks against the configured vertex count and the store depth.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      idx_ok[c] = (CNT_W'(idx_q[c]) < cnt_q) && (32'(idx_q[c]) < 32'(VERTEX_DEPTH));
    end
    case (k_q[1:0])
      2'd0:    cur_idx = idx_q[0];
      2'd1:    cur_idx = idx_q[1];
      default: cur_idx = idx_q[2];
    endcase
    rd_addr = AW'(cur_idx);
  end

  // Edge vectors and multiplier operand selection.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      e1[c] = (CW+1)'($signed(vreg_q[2][c*CW +: CW])) -
              (CW+1)'($signed(vreg_q[0][c*CW +: CW]));
      e2[c] = (CW+1)'($signed(vreg_q[1][c*CW +: CW])) -
              (CW+1)'($signed(vreg_q[0][c*CW +: CW]));
    end
    case (k_q)
      3'd0:    begin op_a = e1[1]; op_b = e2[2]; end
      3'd1:    begin op_a = e1[2]; op_b = e2[1]; end
      3'd2:    begin op_a = e1[2]; op_b = e2[0]; end
      3'd3:    begin op_a = e1[0]; op_b = e2[2]; end
      3'd4:    begin op_a = e1[0]; op_b = e2[1]; end
      default: begin op_a = e1[1]; op_b = e2[0]; end
    endcase
  end

  // Saturating accumulator update, one lane per axis.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      acc_lane[c] = $signed(a_rdata_q[c*ACC_W +: ACC_W]);
      sum_lane[c] = (NVW+1)'(acc_lane[c]) + (NVW+1)'(cross_q[c]);
      if (sum_lane[c] > ACC_HI) begin
        a_wdata[c*ACC_W +: ACC_W] = ACC_HI[ACC_W-1:0];
      end else if (sum_lane[c] < ACC_LO) begin
        a_wdata[c*ACC_W +: ACC_W] = ACC_LO[ACC_W-1:0];
      end else begin
        a_wdata[c*ACC_W +: ACC_W] = sum_lane[c][ACC_W-1:0];
      end
      norm_in[c] = (mode_q == MODE_FACE) ? cross_q[c] : NVW'(acc_lane[c]);
    end
  end

  // Main sequencer.
  always_comb begin
    state_d    = state_q;
    k_d        = k_q;
    cross_d    = cross_q;
    res_n_d    = res_n_q;
    res_err_d  = res_err_q;
    res_kind_d = res_kind_q;
    valid_d    = 1'b0;
    vreg_we    = 1'b0;
    v_we       = 1'b0;
    a_we       = 1'b0;
    v_waddr    = AW'(idx_q[0]);
    a_waddr    = AW'(cur_idx);
    norm_start = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        res_n_d    = '{default: '0};
        res_err_d  = ERR_INDEX;
        res_kind_d = (mode_q == MODE_FACE) ? KIND_FACE : KIND_VERTEX;
        k_d        = '0;
        case (mode_q)
          MODE_LOAD: begin
            if (idx_ok[0]) begin
              v_we    = 1'b1;
              state_d = S_IDLE;
            end else begin
              state_d = S_DONE;
            end
          end
          MODE_FACE: state_d = (&idx_ok) ? S_VRD : S_DONE;
          MODE_READ: state_d = idx_ok[0] ? S_ARD : S_DONE;
          default:   state_d = S_IDLE;
        endcase
      end
      S_VRD: state_d = S_VLT;
      S_VLT: begin
        vreg_we = 1'b1;
        if (k_q == 3'd2) begin
          k_d     = '0;
          cross_d = '{default: '0};
          state_d = S_MUL;
        end else begin
          k_d     = k_q + 3'd1;
          state_d = S_VRD;
        end
      end
      S_MUL: state_d = S_ADD;
      S_ADD: begin
        // Even steps add the product, odd steps subtract it.
        case (k_q[2:1])
          2'd0: cross_d[0] = k_q[0] ? cross_q[0] - NVW'(prod_q) : cross_q[0] + NVW'(prod_q);
          2'd1: cross_d[1] = k_q[0] ? cross_q[1] - NVW'(prod_q) : cross_q[1] + NVW'(prod_q);
          default: cross_d[2] = k_q[0] ? cross_q[2] - NVW'(prod_q)
                                       : cross_q[2] + NVW'(prod_q);
        endcase
        if (k_q == 3'd5) begin
          k_d     = '0;
          state_d = S_ARD;
        end else begin
          k_d     = k_q + 3'd1;
          state_d = S_MUL;
        end
      end
      S_ARD: state_d = S_AWR;
      S_AWR: begin
        if (mode_q == MODE_FACE) begin
          a_we = 1'b1;
          if (k_q == 3'd2) begin
            state_d = S_NORM;
          end else begin
            k_d     = k_q + 3'd1;
            state_d = S_ARD;
          end
        end else begin
          state_d = S_NORM;
        end
      end
      S_NORM: begin
        norm_start = 1'b1;
        state_d    = S_NWAIT;
      end
      S_NWAIT: begin
        if (norm_res.done) begin
          res_n_d   = '{norm_x, norm_y, norm_z};
          res_err_d = norm_res.zero ? ERR_ZERO : ERR_NONE;
          state_d   = S_DONE;
        end
      end
      S_DONE: begin
        valid_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
    // A successful load also clears the vertex accumulator.
    if (v_we) begin
      a_we    = 1'b1;
      a_waddr = AW'(idx_q[0]);
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      if (cfg_we_i) cnt_q <= cfg_data_i;
    end
  end

  // Command capture and datapath registers.
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start_i) begin
      mode_q   <= mode_i;
      idx_q[0] <= first_index_i;
      idx_q[1] <= second_index_i;
      idx_q[2] <= third_index_i;
      cx_q     <= CW'($unsigned(coord_x_i));
      cy_q     <= CW'($unsigned(coord_y_i));
      cz_q     <= CW'($unsigned(coord_z_i));
    end
    if (vreg_we) vreg_q[k_q[1:0]] <= v_rdata_q;
    prod_q     <= op_a * op_b;
    k_q        <= k_d;
    cross_q    <= cross_d;
    res_n_q    <= res_n_d;
    res_err_q  <= res_err_d;
    res_kind_q <= res_kind_d;
  end

  // Vertex store.
  always_ff @(posedge clk_i) begin
    if (v_we) vmem[v_waddr] <= {cz_q, cy_q, cx_q};
    v_rdata_q <= vmem[rd_addr];
  end

  // Accumulator store; a load writes zero.
  always_ff @(posedge clk_i) begin
    if (a_we) amem[a_waddr] <= v_we ? '0 : a_wdata;
    a_rdata_q <= amem[rd_addr];
  end

  mfvn_norm #(
    .NVW (NVW)
  ) u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (norm_start),
    .vx_i    (norm_in[0]),
    .vy_i    (norm_in[1]),
    .vz_i    (norm_in[2]),
    .res_o   (norm_res),
    .nx_o    (norm_x),
    .ny_o    (norm_y),
    .nz_o    (norm_z)
  );

  assign busy_o        = (state_q != S_IDLE);
  assign valid_o       = valid_q;
  assign normal_x_o    = $signed(res_n_q[0]);
  assign normal_y_o    = $signed(res_n_q[1]);
  assign normal_z_o    = $signed(res_n_q[2]);
  assign normal_kind_o = res_kind_q;
  assign error_code_o  = res_err_q;

`ifndef SYNTHESIS
  // A result is shown only after its transaction has finished.
  a_valid_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy_o) else $error("result strobe while busy");

  // Strobes are single cycle.
  a_valid_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o) else $error("result strobe held");

  // Error results carry a zero vector.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && error_code_o != ERR_NONE) |->
      (normal_x_o == '0 && normal_y_o == '0 && normal_z_o == '0))
    else $error("nonzero normal on error");

  // Unit components stay within one in Q1.14.
  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && error_code_o == ERR_NONE) |->
      (normal_x_o <= 16'sd16384 && normal_x_o >= -16'sd16384 &&
       normal_y_o <= 16'sd16384 && normal_y_o >= -16'sd16384 &&
       normal_z_o <= 16'sd16384 && normal_z_o >= -16'sd16384))
    else $error("normal component out of range");

  // Face results never come with the vertex kind.
  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && mode_q == MODE_FACE) |-> (normal_kind_o == KIND_FACE))
    else $error("wrong result kind");
`endif

endmodule
